// File: rtl/core/assert_macros.svh
// Assertion macros for the port-level checker of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is active.
`define KCE_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("kce assertion failed");

// Clocked assertion that also holds during reset.
`define KCE_ASSERT_RST(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("kce reset assertion failed");

`endif

// File: rtl/core/kce_pkg.sv
// Types and constants shared by the k-means cluster engine.
`default_nettype none

package kce_pkg;

  localparam int unsigned KindW   = 3;
  localparam int unsigned ItemW   = 10;
  localparam int unsigned DimW    = 3;
  localparam int unsigned ValueW  = 16;
  localparam int unsigned LabelW  = 4;
  localparam int unsigned UpdW    = 16;
  localparam int unsigned NclW    = 4;
  localparam int unsigned NdimW   = 4;
  localparam int unsigned NptsW   = 11;
  localparam int unsigned PaddrW  = 4;
  localparam int unsigned PdataW  = 32;

  localparam logic [KindW-1:0] KindLoadCent  = 3'd0;
  localparam logic [KindW-1:0] KindLoadPoint = 3'd1;
  localparam logic [KindW-1:0] KindStart     = 3'd2;
  localparam logic [KindW-1:0] KindReadLabel = 3'd3;
  localparam logic [KindW-1:0] KindReadCent  = 3'd4;

  localparam logic [1:0] RegNumClusters = 2'd0;
  localparam logic [1:0] RegNumDims     = 2'd1;
  localparam logic [1:0] RegNumPoints   = 2'd2;
  localparam logic [1:0] RegMaxUpdates  = 2'd3;

  localparam logic [NclW-1:0]  NclRst     = 4'd2;
  localparam logic [NdimW-1:0] NdimRst    = 4'd2;
  localparam logic [NptsW-1:0] NptsRst    = 11'd1;
  localparam logic [UpdW-1:0]  MaxUpdRst  = 16'd1001;

  typedef struct packed {
    logic load_cent;
    logic load_pt;
    logic rd_item;
    logic rd_label;
    logic rd_pt;
    logic rd_cent;
    logic rd_sum;
    logic sum_by_lab;
    logic clr_label;
    logic pres_clr;
    logic dist_clr;
    logic diff_en;
    logic sq_en;
    logic acc_en;
    logic cmp_en;
    logic lab_wr;
    logic sum_clr_wr;
    logic cnt_clr;
    logic cnt_inc;
    logic sum_wr;
    logic div_start;
    logic cent_upd;
    logic out_read;
    logic out_start;
  } kce_cmd_t;

  typedef struct packed {
    logic same;
    logic lab_ok;
    logic cnt_zero;
    logic div_done;
  } kce_status_t;

endpackage

`default_nettype wire

// File: rtl/core/kce_div.sv
// Iterative signed-by-unsigned divider, one quotient bit per cycle.
`default_nettype none

module kce_div #(
  parameter int unsigned SumW = 27,
  parameter int unsigned CntW = 11
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic signed [SumW-1:0] dividend_i,
  input  logic [CntW-1:0]        divisor_i,
  output logic                   done_o,
  output logic signed [SumW-1:0] quot_o
);

  localparam int unsigned StepW = $clog2(SumW);

  logic [SumW-1:0]  a_q;
  logic [CntW-1:0]  rem_q;
  logic [CntW-1:0]  dvs_q;
  logic             neg_q;
  logic             busy_q;
  logic             done_q;
  logic [StepW-1:0] step_q;
  logic [CntW:0]    rem_sh;
  logic [CntW:0]    rem_nx;
  logic             ge;

  assign rem_sh = {rem_q, a_q[SumW-1]};
  assign ge     = rem_sh >= {1'b0, dvs_q};
  assign rem_nx = ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= dividend_i[SumW-1] ? SumW'(-dividend_i) : dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
      neg_q <= dividend_i[SumW-1];
    end else if (busy_q) begin
      a_q   <= {a_q[SumW-2:0], ge};
      rem_q <= CntW'(rem_nx);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + 1'b1;
      if (step_q == StepW'(SumW - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? -a_q : a_q;

endmodule

`default_nettype wire

// File: rtl/core/kce_dp.sv
// Datapath: stores, distance arithmetic, accumulators and result registers.
`default_nettype none

module kce_dp #(
  parameter int unsigned MaxPoints   = 1024,
  parameter int unsigned MaxDims     = 8,
  parameter int unsigned MaxClusters = 8,
  localparam int unsigned PiW = $clog2(MaxPoints),
  localparam int unsigned CiW = $clog2(MaxClusters),
  localparam int unsigned DiW = (MaxDims > 1) ? $clog2(MaxDims) : 1
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  kce_pkg::kce_cmd_t                cmd_i,
  output kce_pkg::kce_status_t             status_o,
  input  logic [PiW-1:0]                   pt_idx_i,
  input  logic [CiW-1:0]                   cl_idx_i,
  input  logic [DiW-1:0]                   dm_idx_i,
  input  logic [CiW-1:0]                   k_m1_i,
  input  logic [kce_pkg::UpdW-1:0]         count_i,
  input  logic [kce_pkg::KindW-1:0]        in_kind_i,
  input  logic [kce_pkg::ItemW-1:0]        in_item_i,
  input  logic [kce_pkg::DimW-1:0]         in_dim_i,
  input  logic signed [kce_pkg::ValueW-1:0] in_value_i,
  output logic [kce_pkg::LabelW-1:0]       out_label_o,
  output logic signed [kce_pkg::ValueW-1:0] out_coord_o,
  output logic [kce_pkg::UpdW-1:0]         out_update_count_o,
  output logic                             out_converged_o,
  output logic                             out_empty_cluster_o
);

  localparam int unsigned LbW   = $clog2(MaxClusters + 1);
  localparam int unsigned PaW   = $clog2(MaxPoints * MaxDims);
  localparam int unsigned CaW   = $clog2(MaxClusters * MaxDims);
  localparam int unsigned SumW  = $clog2(MaxPoints) + 17;
  localparam int unsigned CntW  = $clog2(MaxPoints + 1);
  localparam int unsigned DistW = 32 + $clog2(MaxDims);
  localparam int unsigned VW    = kce_pkg::ValueW;

  logic signed [VW-1:0]   pt_mem   [MaxPoints*MaxDims];
  logic signed [VW-1:0]   cent_mem [MaxClusters*MaxDims];
  logic [LbW-1:0]         lab_mem  [MaxPoints];
  logic signed [SumW-1:0] sum_mem  [MaxClusters*MaxDims];

  logic signed [VW-1:0]   pt_rd_q;
  logic signed [VW-1:0]   cent_rd_q;
  logic [LbW-1:0]         lab_rd_q;
  logic signed [SumW-1:0] sum_rd_q;

  logic signed [VW:0]     diff_q;
  logic signed [2*VW+1:0] prod;
  logic [31:0]            sq_q;
  logic [DistW-1:0]       dist_q;
  logic [DistW-1:0]       best_q;
  logic [LbW-1:0]         best_lab_q;

  logic                   same_q;
  logic [MaxClusters-1:0] present_q;
  logic [CntW-1:0]        cnt_q [MaxClusters];
  logic                   rsp_lab_q;
  logic                   rsp_ok_q;
  logic [kce_pkg::UpdW+1:0] status_q;
  logic [kce_pkg::LabelW-1:0] out_label_q;
  logic signed [VW-1:0]   out_coord_q;

  logic                   dim_ok;
  logic                   item_pt_ok;
  logic                   item_cl_ok;
  logic [PaW-1:0]         pa_in;
  logic [PaW-1:0]         pa_run;
  logic [CaW-1:0]         ca_in;
  logic [CaW-1:0]         ca_run;
  logic [CaW-1:0]         sa_lab;
  logic [CaW-1:0]         sum_raddr;
  logic [CaW-1:0]         cent_raddr;
  logic [PiW-1:0]         lab_raddr;
  logic [CiW-1:0]         lab_cl;
  logic                   empty;
  logic                   div_done;
  logic signed [SumW-1:0] quot;

  assign dim_ok     = 32'(in_dim_i) < MaxDims;
  assign item_pt_ok = 32'(in_item_i) < MaxPoints;
  assign item_cl_ok = 32'(in_item_i) < MaxClusters;
  assign pa_in      = PaW'(32'(in_item_i) * MaxDims + 32'(in_dim_i));
  assign ca_in      = CaW'(32'(in_item_i) * MaxDims + 32'(in_dim_i));
  assign pa_run     = PaW'(32'(pt_idx_i) * MaxDims + 32'(dm_idx_i));
  assign ca_run     = CaW'(32'(cl_idx_i) * MaxDims + 32'(dm_idx_i));
  assign lab_cl     = CiW'(lab_rd_q - LbW'(1));
  assign sa_lab     = CaW'(32'(lab_cl) * MaxDims + 32'(dm_idx_i));
  assign sum_raddr  = cmd_i.sum_by_lab ? sa_lab : ca_run;
  assign cent_raddr = cmd_i.rd_item ? ca_in : ca_run;
  assign lab_raddr  = cmd_i.rd_item ? PiW'(in_item_i) : pt_idx_i;

  // Point store
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_pt && item_pt_ok && dim_ok) begin
      pt_mem[pa_in] <= in_value_i;
    end
    if (cmd_i.rd_pt) begin
      pt_rd_q <= pt_mem[pa_run];
    end
  end

  // Centroid store
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_cent && item_cl_ok && dim_ok) begin
      cent_mem[ca_in] <= in_value_i;
    end else if (cmd_i.cent_upd) begin
      cent_mem[ca_run] <= VW'(quot);
    end
    if (cmd_i.rd_cent) begin
      cent_rd_q <= cent_mem[cent_raddr];
    end
  end

  // Label store
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_label) begin
      lab_mem[pt_idx_i] <= '0;
    end else if (cmd_i.lab_wr) begin
      lab_mem[pt_idx_i] <= best_lab_q;
    end
    if (cmd_i.rd_label) begin
      lab_rd_q <= lab_mem[lab_raddr];
    end
  end

  // Sum accumulators
  always_ff @(posedge clk_i) begin
    if (cmd_i.sum_clr_wr) begin
      sum_mem[ca_run] <= '0;
    end else if (cmd_i.sum_wr) begin
      sum_mem[sa_lab] <= sum_rd_q + SumW'(pt_rd_q);
    end
    if (cmd_i.rd_sum) begin
      sum_rd_q <= sum_mem[sum_raddr];
    end
  end

  assign prod = diff_q * diff_q;

  // Distance pipeline
  always_ff @(posedge clk_i) begin
    if (cmd_i.diff_en) begin
      diff_q <= {pt_rd_q[VW-1], pt_rd_q} - {cent_rd_q[VW-1], cent_rd_q};
    end
    if (cmd_i.sq_en) begin
      sq_q <= prod[31:0];
    end
    if (cmd_i.dist_clr || cmd_i.cmp_en) begin
      dist_q <= '0;
    end else if (cmd_i.acc_en) begin
      dist_q <= dist_q + DistW'(sq_q);
    end
    if (cmd_i.cmp_en && (cl_idx_i == '0 || dist_q < best_q)) begin
      best_q     <= dist_q;
      best_lab_q <= LbW'(cl_idx_i) + LbW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      same_q    <= 1'b1;
      present_q <= '0;
      for (int c = 0; c < MaxClusters; c++) begin
        cnt_q[c] <= '0;
      end
    end else begin
      if (cmd_i.pres_clr) begin
        same_q    <= 1'b1;
        present_q <= '0;
      end else if (cmd_i.lab_wr) begin
        if (lab_rd_q != best_lab_q) begin
          same_q <= 1'b0;
        end
        for (int c = 0; c < MaxClusters; c++) begin
          if (best_lab_q == LbW'(c + 1)) begin
            present_q[c] <= 1'b1;
          end
        end
      end
      for (int c = 0; c < MaxClusters; c++) begin
        if (cmd_i.cnt_clr) begin
          cnt_q[c] <= '0;
        end else if (cmd_i.cnt_inc && lab_cl == CiW'(c)) begin
          cnt_q[c] <= cnt_q[c] + 1'b1;
        end
      end
    end
  end

  always_comb begin
    empty = 1'b0;
    for (int c = 0; c < MaxClusters; c++) begin
      if (CiW'(c) <= k_m1_i && !present_q[c]) begin
        empty = 1'b1;
      end
    end
  end

  kce_div #(
    .SumW(SumW),
    .CntW(CntW)
  ) u_kce_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .dividend_i(sum_rd_q),
    .divisor_i (cnt_q[cl_idx_i]),
    .done_o    (div_done),
    .quot_o    (quot)
  );

  // Result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_item) begin
      rsp_lab_q <= (in_kind_i == kce_pkg::KindReadLabel);
      rsp_ok_q  <= (in_kind_i == kce_pkg::KindReadLabel) ? item_pt_ok
                                                          : (item_cl_ok && dim_ok);
    end
    if (cmd_i.out_read) begin
      out_label_q <= (rsp_lab_q && rsp_ok_q) ? kce_pkg::LabelW'(lab_rd_q) : '0;
      out_coord_q <= (!rsp_lab_q && rsp_ok_q) ? cent_rd_q : '0;
    end else if (cmd_i.out_start) begin
      out_label_q <= '0;
      out_coord_q <= '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= '0;
    end else if (cmd_i.out_start) begin
      status_q <= {empty, same_q, count_i};
    end
  end

  assign status_o.same     = same_q;
  assign status_o.lab_ok   = (lab_rd_q != '0) && (LbW'(lab_rd_q - LbW'(1)) <= LbW'(k_m1_i));
  assign status_o.cnt_zero = (cnt_q[cl_idx_i] == '0);
  assign status_o.div_done = div_done;

  assign out_label_o         = out_label_q;
  assign out_coord_o         = out_coord_q;
  assign out_update_count_o  = status_q[kce_pkg::UpdW-1:0];
  assign out_converged_o     = status_q[kce_pkg::UpdW];
  assign out_empty_cluster_o = status_q[kce_pkg::UpdW+1];

endmodule

`default_nettype wire

// File: rtl/core/kce_ctrl.sv
// Controller: sequencing state machine, loop counters and handshakes.
`default_nettype none

module kce_ctrl #(
  parameter int unsigned MaxPoints   = 1024,
  parameter int unsigned MaxDims     = 8,
  parameter int unsigned MaxClusters = 8,
  localparam int unsigned PiW = $clog2(MaxPoints),
  localparam int unsigned CiW = $clog2(MaxClusters),
  localparam int unsigned DiW = (MaxDims > 1) ? $clog2(MaxDims) : 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [kce_pkg::KindW-1:0]   in_kind_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  input  logic [kce_pkg::NclW-1:0]    num_clusters_i,
  input  logic [kce_pkg::NdimW-1:0]   num_dims_i,
  input  logic [kce_pkg::NptsW-1:0]   num_points_i,
  input  logic [kce_pkg::UpdW-1:0]    max_updates_i,
  input  kce_pkg::kce_status_t        status_i,
  output kce_pkg::kce_cmd_t           cmd_o,
  output logic [PiW-1:0]              pt_idx_o,
  output logic [CiW-1:0]              cl_idx_o,
  output logic [DiW-1:0]              dm_idx_o,
  output logic [CiW-1:0]              k_m1_o,
  output logic [kce_pkg::UpdW-1:0]    count_o
);

  typedef enum logic [20:0] {
    S_CLEAR  = 21'h000001,
    S_IDLE   = 21'h000002,
    S_RESP   = 21'h000004,
    S_A_INIT = 21'h000008,
    S_A_PT   = 21'h000010,
    S_A_RD   = 21'h000020,
    S_A_DIFF = 21'h000040,
    S_A_SQ   = 21'h000080,
    S_A_ACC  = 21'h000100,
    S_A_CMP  = 21'h000200,
    S_A_WR   = 21'h000400,
    S_A_END  = 21'h000800,
    S_DONE   = 21'h001000,
    S_U_CLR  = 21'h002000,
    S_U_PT   = 21'h004000,
    S_U_LAB  = 21'h008000,
    S_U_RD   = 21'h010000,
    S_U_WR   = 21'h020000,
    S_U_DRD  = 21'h040000,
    S_U_DST  = 21'h080000,
    S_U_DWT  = 21'h100000
  } state_e;

  state_e                   state_q, state_d;
  logic [PiW-1:0]           i_q, i_d;
  logic [CiW-1:0]           j_q, j_d;
  logic [DiW-1:0]           m_q, m_d;
  logic [CiW-1:0]           k_m1_q, k_m1_d;
  logic [DiW-1:0]           dims_m1_q, dims_m1_d;
  logic [PiW-1:0]           pts_m1_q, pts_m1_d;
  logic [kce_pkg::UpdW-1:0] limit_q, limit_d;
  logic [kce_pkg::UpdW-1:0] count_q, count_d;
  logic                     out_valid_q, out_valid_d;
  logic                     accept;
  logic                     last_i;
  logic                     last_j;
  logic                     last_m;
  kce_pkg::kce_cmd_t        cmd;

  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign last_i     = (i_q == pts_m1_q);
  assign last_j     = (j_q == k_m1_q);
  assign last_m     = (m_q == dims_m1_q);

  always_comb begin
    int unsigned kv;
    int unsigned dv;
    int unsigned pv;
    kv = (num_clusters_i == '0) ? 1 :
         ((32'(num_clusters_i) > MaxClusters) ? MaxClusters : 32'(num_clusters_i));
    dv = (num_dims_i == '0) ? 1 :
         ((32'(num_dims_i) > MaxDims) ? MaxDims : 32'(num_dims_i));
    pv = (num_points_i == '0) ? 1 :
         ((32'(num_points_i) > MaxPoints) ? MaxPoints : 32'(num_points_i));
    k_m1_d    = k_m1_q;
    dims_m1_d = dims_m1_q;
    pts_m1_d  = pts_m1_q;
    limit_d   = limit_q;
    state_d   = state_q;
    i_d       = i_q;
    j_d       = j_q;
    m_d       = m_q;
    count_d   = count_q;
    cmd       = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd.clr_label = 1'b1;
        if (i_q == PiW'(MaxPoints - 1)) begin
          i_d     = '0;
          state_d = S_IDLE;
        end else begin
          i_d = i_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (accept) begin
          unique case (in_kind_i)
            kce_pkg::KindLoadCent:  cmd.load_cent = 1'b1;
            kce_pkg::KindLoadPoint: cmd.load_pt   = 1'b1;
            kce_pkg::KindStart: begin
              k_m1_d    = CiW'(kv - 1);
              dims_m1_d = DiW'(dv - 1);
              pts_m1_d  = PiW'(pv - 1);
              limit_d   = max_updates_i;
              count_d   = '0;
              state_d   = S_A_INIT;
            end
            kce_pkg::KindReadLabel, kce_pkg::KindReadCent: begin
              cmd.rd_item  = 1'b1;
              cmd.rd_label = 1'b1;
              cmd.rd_cent  = 1'b1;
              state_d      = S_RESP;
            end
            default: ;
          endcase
        end
      end
      S_RESP: begin
        cmd.out_read = 1'b1;
        state_d      = S_IDLE;
      end
      S_A_INIT: begin
        cmd.pres_clr = 1'b1;
        i_d          = '0;
        state_d      = S_A_PT;
      end
      S_A_PT: begin
        cmd.rd_label = 1'b1;
        cmd.dist_clr = 1'b1;
        j_d          = '0;
        m_d          = '0;
        state_d      = S_A_RD;
      end
      S_A_RD: begin
        cmd.rd_pt   = 1'b1;
        cmd.rd_cent = 1'b1;
        state_d     = S_A_DIFF;
      end
      S_A_DIFF: begin
        cmd.diff_en = 1'b1;
        state_d     = S_A_SQ;
      end
      S_A_SQ: begin
        cmd.sq_en = 1'b1;
        state_d   = S_A_ACC;
      end
      S_A_ACC: begin
        cmd.acc_en = 1'b1;
        if (last_m) begin
          state_d = S_A_CMP;
        end else begin
          m_d     = m_q + 1'b1;
          state_d = S_A_RD;
        end
      end
      S_A_CMP: begin
        cmd.cmp_en = 1'b1;
        m_d        = '0;
        if (last_j) begin
          state_d = S_A_WR;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = S_A_RD;
        end
      end
      S_A_WR: begin
        cmd.lab_wr = 1'b1;
        if (last_i) begin
          state_d = S_A_END;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = S_A_PT;
        end
      end
      S_A_END: begin
        if (status_i.same || count_q >= limit_q) begin
          state_d = S_DONE;
        end else begin
          count_d = count_q + 1'b1;
          j_d     = '0;
          m_d     = '0;
          state_d = S_U_CLR;
        end
      end
      S_DONE: begin
        cmd.out_start = 1'b1;
        state_d       = S_IDLE;
      end
      S_U_CLR: begin
        cmd.sum_clr_wr = 1'b1;
        cmd.cnt_clr    = 1'b1;
        if (last_m) begin
          m_d = '0;
          if (last_j) begin
            i_d     = '0;
            state_d = S_U_PT;
          end else begin
            j_d = j_q + 1'b1;
          end
        end else begin
          m_d = m_q + 1'b1;
        end
      end
      S_U_PT: begin
        cmd.rd_label = 1'b1;
        m_d          = '0;
        state_d      = S_U_LAB;
      end
      S_U_LAB: begin
        if (status_i.lab_ok) begin
          cmd.cnt_inc = 1'b1;
          state_d     = S_U_RD;
        end else if (last_i) begin
          j_d     = '0;
          state_d = S_U_DRD;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = S_U_PT;
        end
      end
      S_U_RD: begin
        cmd.rd_pt      = 1'b1;
        cmd.rd_sum     = 1'b1;
        cmd.sum_by_lab = 1'b1;
        state_d        = S_U_WR;
      end
      S_U_WR: begin
        cmd.sum_wr = 1'b1;
        if (!last_m) begin
          m_d     = m_q + 1'b1;
          state_d = S_U_RD;
        end else if (last_i) begin
          j_d     = '0;
          m_d     = '0;
          state_d = S_U_DRD;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = S_U_PT;
        end
      end
      S_U_DRD: begin
        if (status_i.cnt_zero) begin
          m_d = '0;
          if (last_j) begin
            state_d = S_A_INIT;
          end else begin
            j_d = j_q + 1'b1;
          end
        end else begin
          cmd.rd_sum = 1'b1;
          state_d    = S_U_DST;
        end
      end
      S_U_DST: begin
        cmd.div_start = 1'b1;
        state_d       = S_U_DWT;
      end
      S_U_DWT: begin
        if (status_i.div_done) begin
          cmd.cent_upd = 1'b1;
          state_d      = S_U_DRD;
          if (last_m) begin
            m_d = '0;
            if (last_j) begin
              state_d = S_A_INIT;
            end else begin
              j_d = j_q + 1'b1;
            end
          end else begin
            m_d = m_q + 1'b1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = cmd.out_read || cmd.out_start || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      i_q         <= '0;
      j_q         <= '0;
      m_q         <= '0;
      k_m1_q      <= '0;
      dims_m1_q   <= '0;
      pts_m1_q    <= '0;
      limit_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      j_q         <= j_d;
      m_q         <= m_d;
      k_m1_q      <= k_m1_d;
      dims_m1_q   <= dims_m1_d;
      pts_m1_q    <= pts_m1_d;
      limit_q     <= limit_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign cmd_o       = cmd;
  assign out_valid_o = out_valid_q;
  assign pt_idx_o    = i_q;
  assign cl_idx_o    = j_q;
  assign dm_idx_o    = m_q;
  assign k_m1_o      = k_m1_q;
  assign count_o     = count_q;

endmodule

`default_nettype wire

// File: rtl/core/kmeans_cluster_engine.sv
// A load is written into its store on acceptance; a read passes through the store
// read and result registers. On start, assign passes label each point with its nearest
// centroid and update passes recompute centroids with the bit-serial divider, repeated
// until done. One transaction in flight; sequential store accesses and the divider
// set the pace. After the asynchronous, active-low reset, a label clear of all MaxPoints
// entries runs before the first input is taken (configuration writes still accepted).
`default_nettype none

module kmeans_cluster_engine #(
  parameter int unsigned MaxPoints   = 1024,
  parameter int unsigned MaxDims     = 8,
  parameter int unsigned MaxClusters = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [kce_pkg::KindW-1:0]         in_kind_i,
  input  logic [kce_pkg::ItemW-1:0]         in_item_index_i,
  input  logic [kce_pkg::DimW-1:0]          in_dim_index_i,
  input  logic signed [kce_pkg::ValueW-1:0] in_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [kce_pkg::LabelW-1:0]        out_label_o,
  output logic signed [kce_pkg::ValueW-1:0] out_coord_o,
  output logic [kce_pkg::UpdW-1:0]          out_update_count_o,
  output logic                              out_converged_o,
  output logic                              out_empty_cluster_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [kce_pkg::PaddrW-1:0]        paddr,
  input  logic [kce_pkg::PdataW-1:0]        pwdata,
  output logic [kce_pkg::PdataW-1:0]        prdata,
  output logic                              pready
);

  localparam int unsigned PiW = $clog2(MaxPoints);
  localparam int unsigned CiW = $clog2(MaxClusters);
  localparam int unsigned DiW = (MaxDims > 1) ? $clog2(MaxDims) : 1;

  logic [kce_pkg::NclW-1:0]  ncl_q;
  logic [kce_pkg::NdimW-1:0] ndim_q;
  logic [kce_pkg::NptsW-1:0] npts_q;
  logic [kce_pkg::UpdW-1:0]  maxu_q;
  logic                      cfg_wr;
  logic [1:0]                reg_idx;

  kce_pkg::kce_cmd_t         cmd;
  kce_pkg::kce_status_t      status;
  logic [PiW-1:0]            pt_idx;
  logic [CiW-1:0]            cl_idx;
  logic [DiW-1:0]            dm_idx;
  logic [CiW-1:0]            k_m1;
  logic [kce_pkg::UpdW-1:0]  count;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ncl_q  <= kce_pkg::NclRst;
      ndim_q <= kce_pkg::NdimRst;
      npts_q <= kce_pkg::NptsRst;
      maxu_q <= kce_pkg::MaxUpdRst;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        kce_pkg::RegNumClusters: ncl_q  <= pwdata[kce_pkg::NclW-1:0];
        kce_pkg::RegNumDims:     ndim_q <= pwdata[kce_pkg::NdimW-1:0];
        kce_pkg::RegNumPoints:   npts_q <= pwdata[kce_pkg::NptsW-1:0];
        kce_pkg::RegMaxUpdates:  maxu_q <= pwdata[kce_pkg::UpdW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      kce_pkg::RegNumClusters: prdata = kce_pkg::PdataW'(ncl_q);
      kce_pkg::RegNumDims:     prdata = kce_pkg::PdataW'(ndim_q);
      kce_pkg::RegNumPoints:   prdata = kce_pkg::PdataW'(npts_q);
      kce_pkg::RegMaxUpdates:  prdata = kce_pkg::PdataW'(maxu_q);
      default:                 prdata = '0;
    endcase
  end

  kce_ctrl #(
    .MaxPoints  (MaxPoints),
    .MaxDims    (MaxDims),
    .MaxClusters(MaxClusters)
  ) u_kce_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_kind_i     (in_kind_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .num_clusters_i(ncl_q),
    .num_dims_i    (ndim_q),
    .num_points_i  (npts_q),
    .max_updates_i (maxu_q),
    .status_i      (status),
    .cmd_o         (cmd),
    .pt_idx_o      (pt_idx),
    .cl_idx_o      (cl_idx),
    .dm_idx_o      (dm_idx),
    .k_m1_o        (k_m1),
    .count_o       (count)
  );

  kce_dp #(
    .MaxPoints  (MaxPoints),
    .MaxDims    (MaxDims),
    .MaxClusters(MaxClusters)
  ) u_kce_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .pt_idx_i           (pt_idx),
    .cl_idx_i           (cl_idx),
    .dm_idx_i           (dm_idx),
    .k_m1_i             (k_m1),
    .count_i            (count),
    .in_kind_i          (in_kind_i),
    .in_item_i          (in_item_index_i),
    .in_dim_i           (in_dim_index_i),
    .in_value_i         (in_value_i),
    .out_label_o        (out_label_o),
    .out_coord_o        (out_coord_o),
    .out_update_count_o (out_update_count_o),
    .out_converged_o    (out_converged_o),
    .out_empty_cluster_o(out_empty_cluster_o)
  );

endmodule

`default_nettype wire

// File: rtl/core/kce_checker.sv
// Port-level checker for the k-means cluster engine, bound to the top level.
`default_nettype none

`include "assert_macros.svh"

module kce_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic [kce_pkg::KindW-1:0]         in_kind_i,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic [kce_pkg::LabelW-1:0]        out_label_o,
  input logic signed [kce_pkg::ValueW-1:0] out_coord_o
);

  logic res_kind;

  assign res_kind = (in_kind_i == kce_pkg::KindStart) ||
                    (in_kind_i == kce_pkg::KindReadLabel) ||
                    (in_kind_i == kce_pkg::KindReadCent);

  `KCE_ASSERT_RST(a_quiet_in_reset, !rst_ni |-> !in_ready_o && !out_valid_o)

  `KCE_ASSERT(a_out_held, out_valid_o && !out_ready_i |=> out_valid_o)

  `KCE_ASSERT(a_no_take_while_blocked, out_valid_o && !out_ready_i |-> !in_ready_o)

  `KCE_ASSERT(a_busy_after_result_kind, in_valid_i && in_ready_o && res_kind |=> !in_ready_o)

  `KCE_ASSERT(a_one_payload_field, out_valid_o |-> out_label_o == '0 || out_coord_o == '0)

endmodule

bind kmeans_cluster_engine kce_checker u_kce_checker (.*);

`default_nettype wire

// File: tb/sv/kmeans_result_checker.sv
// Checker for the k-means cluster engine: shadow model, expected results and comparison.
module kmeans_result_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  logic [kce_pkg::KindW-1:0]         in_kind_i,
  input  logic [kce_pkg::ItemW-1:0]         in_item_index_i,
  input  logic [kce_pkg::DimW-1:0]          in_dim_index_i,
  input  logic signed [kce_pkg::ValueW-1:0] in_value_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  logic [kce_pkg::LabelW-1:0]        out_label_i,
  input  logic signed [kce_pkg::ValueW-1:0] out_coord_i,
  input  logic [kce_pkg::UpdW-1:0]          out_update_count_i,
  input  logic                              out_converged_i,
  input  logic                              out_empty_cluster_i,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [kce_pkg::PaddrW-1:0]        paddr,
  input  logic [kce_pkg::PdataW-1:0]        pwdata,
  input  logic                              pready,
  output int unsigned                       error_count_o,
  output int unsigned                       pending_o
);
  import kce_pkg::*;

  localparam int NPt  = 1024;
  localparam int NDim = 8;
  localparam int NCl  = 8;

  typedef struct packed {
    logic [LabelW-1:0]        label;
    logic signed [ValueW-1:0] coord;
    logic [UpdW-1:0]          upd;
    logic                     conv;
    logic                     empt;
  } cluster_result_t;

  cluster_result_t awaited_results[$];

  logic signed [ValueW-1:0] point_mem[NPt*NDim];
  logic [LabelW-1:0]        label_mem[NPt];
  logic signed [ValueW-1:0] cent_mem[NCl*NDim];
  logic [NclW-1:0]          reg_k;
  logic [NdimW-1:0]         reg_d;
  logic [NptsW-1:0]         reg_n;
  logic [UpdW-1:0]          reg_lim;
  logic [UpdW-1:0]          st_count;
  logic                     st_conv;
  logic                     st_empty;
  int unsigned              errors;

  assign error_count_o = errors;
  assign pending_o     = awaited_results.size();

  function automatic int sat(int v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint sq_distance(int p, int c, int d);
    longint acc;
    longint df;
    acc = 0;
    for (int m = 0; m < d; m++) begin
      df = longint'(point_mem[p*NDim+m]) - longint'(cent_mem[c*NDim+m]);
      acc += df * df;
    end
    return acc;
  endfunction

  function automatic bit nearest_pass(int k, int d, int n);
    bit same;
    longint best;
    longint dd;
    int lab;
    same = 1'b1;
    for (int i = 0; i < n; i++) begin
      best = sq_distance(i, 0, d);
      lab = 1;
      for (int j = 1; j < k; j++) begin
        dd = sq_distance(i, j, d);
        if (dd < best) begin
          best = dd;
          lab = j + 1;
        end
      end
      if (label_mem[i] != lab) same = 1'b0;
      label_mem[i] = lab;
    end
    return same;
  endfunction

  function automatic void mean_pass(int k, int d, int n);
    longint sums[NCl*NDim];
    int cnt[NCl];
    int lab;
    for (int c = 0; c < NCl*NDim; c++) sums[c] = 0;
    for (int c = 0; c < NCl; c++) cnt[c] = 0;
    for (int i = 0; i < n; i++) begin
      lab = label_mem[i];
      if (lab >= 1 && lab <= k) begin
        cnt[lab-1]++;
        for (int m = 0; m < d; m++) sums[(lab-1)*NDim+m] += point_mem[i*NDim+m];
      end
    end
    for (int c = 0; c < k; c++) begin
      if (cnt[c] != 0) begin
        for (int m = 0; m < d; m++)
          cent_mem[c*NDim+m] = ValueW'(sums[c*NDim+m] / longint'(cnt[c]));
      end
    end
  endfunction

  function automatic void run_clustering();
    int k;
    int d;
    int n;
    int count;
    bit conv;
    bit found;
    k = sat(reg_k, NCl);
    d = sat(reg_d, NDim);
    n = sat(reg_n, NPt);
    count = 0;
    conv = nearest_pass(k, d, n);
    while (!conv && count < reg_lim) begin
      count++;
      mean_pass(k, d, n);
      conv = nearest_pass(k, d, n);
    end
    st_empty = 1'b0;
    for (int c = 1; c <= k; c++) begin
      found = 1'b0;
      for (int i = 0; i < n; i++) if (label_mem[i] == c) found = 1'b1;
      if (!found) st_empty = 1'b1;
    end
    st_count = count;
    st_conv = conv;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cluster_result_t r;
    cluster_result_t e;
    bit gives;
    if (!rst_ni) begin
      for (int i = 0; i < NPt; i++) label_mem[i] = '0;
      for (int i = 0; i < NPt*NDim; i++) point_mem[i] = '0;
      for (int i = 0; i < NCl*NDim; i++) cent_mem[i] = '0;
      reg_k = NclRst;
      reg_d = NdimRst;
      reg_n = NptsRst;
      reg_lim = MaxUpdRst;
      st_count = '0;
      st_conv = 1'b0;
      st_empty = 1'b0;
      errors = 0;
      awaited_results.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          RegNumClusters: reg_k = pwdata[NclW-1:0];
          RegNumDims:     reg_d = pwdata[NdimW-1:0];
          RegNumPoints:   reg_n = pwdata[NptsW-1:0];
          RegMaxUpdates:  reg_lim = pwdata[UpdW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        gives = 1'b1;
        r = '0;
        case (in_kind_i)
          KindLoadCent: begin
            gives = 1'b0;
            if (in_item_index_i < NCl) cent_mem[in_item_index_i*NDim+in_dim_index_i] = in_value_i;
          end
          KindLoadPoint: begin
            gives = 1'b0;
            point_mem[in_item_index_i*NDim+in_dim_index_i] = in_value_i;
          end
          KindStart: run_clustering();
          KindReadLabel: r.label = label_mem[in_item_index_i];
          KindReadCent: begin
            if (in_item_index_i < NCl) r.coord = cent_mem[in_item_index_i*NDim+in_dim_index_i];
          end
          default: gives = 1'b0;
        endcase
        if (gives) begin
          r.upd = st_count;
          r.conv = st_conv;
          r.empt = st_empty;
          awaited_results.push_back(r);
        end
      end
      if (out_valid_i && out_ready_i) begin
        r.label = out_label_i;
        r.coord = out_coord_i;
        r.upd   = out_update_count_i;
        r.conv  = out_converged_i;
        r.empt  = out_empty_cluster_i;
        if (awaited_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result label=%0d coord=%0d upd=%0d conv=%0b empty=%0b",
                   $time, r.label, r.coord, r.upd, r.conv, r.empt);
        end else begin
          e = awaited_results.pop_front();
          if (r != e) begin
            errors++;
            $display("%0t: mismatch exp label=%0d coord=%0d upd=%0d conv=%0b empty=%0b",
                     $time, e.label, e.coord, e.upd, e.conv, e.empt);
            $display("%0t:          act label=%0d coord=%0d upd=%0d conv=%0b empty=%0b",
                     $time, r.label, r.coord, r.upd, r.conv, r.empt);
          end
        end
      end
    end
  end
endmodule

// File: tb/sv/kmeans_cluster_engine_tb.sv
// Top of the k-means cluster engine testbench: clock, reset, stimulus and verdict.
module kmeans_cluster_engine_tb;
  import kce_pkg::*;

  localparam logic [KindW-1:0] KindSpare5 = 3'd5;
  localparam logic [KindW-1:0] KindSpare6 = 3'd6;
  localparam logic [KindW-1:0] KindSpare7 = 3'd7;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  logic [KindW-1:0] in_kind_i;
  logic [ItemW-1:0] in_item_index_i;
  logic [DimW-1:0] in_dim_index_i;
  logic signed [ValueW-1:0] in_value_i;
  logic out_valid_o;
  logic out_ready_i;
  logic [LabelW-1:0] out_label_o;
  logic signed [ValueW-1:0] out_coord_o;
  logic [UpdW-1:0] out_update_count_o;
  logic out_converged_o;
  logic out_empty_cluster_o;
  logic psel, penable, pwrite, pready;
  logic [PaddrW-1:0] paddr;
  logic [PdataW-1:0] pwdata, prdata;
  int unsigned error_count;
  int unsigned pending;

  bit cent_written[64];
  int burst_left;
  int items_sent;
  bit long_hold;

  kmeans_cluster_engine dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_kind_i, .in_item_index_i,
    .in_dim_index_i, .in_value_i, .out_valid_o, .out_ready_i, .out_label_o,
    .out_coord_o, .out_update_count_o, .out_converged_o, .out_empty_cluster_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  kmeans_result_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .in_kind_i,
    .in_item_index_i, .in_dim_index_i, .in_value_i, .out_valid_i(out_valid_o),
    .out_ready_i, .out_label_i(out_label_o), .out_coord_i(out_coord_o),
    .out_update_count_i(out_update_count_o), .out_converged_i(out_converged_o),
    .out_empty_cluster_i(out_empty_cluster_o), .psel, .penable, .pwrite, .paddr,
    .pwdata, .pready, .error_count_o(error_count), .pending_o(pending)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  initial begin
    #40000000;
    $display("[kmeans_cluster_engine] ERROR");
    $finish;
  end

  // receiver: stall pattern changes after each random span
  initial begin
    int mode;
    int span;
    out_ready_i = 1'b0;
    mode = 0;
    span = 0;
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        out_ready_i = 1'b0;
        repeat (400) @(negedge clk_i);
        long_hold = 1'b0;
      end
      if (span == 0) begin
        mode = $urandom_range(0, 2);
        span = $urandom_range(10, 120);
      end
      span--;
      case (mode)
        0: out_ready_i = 1'b1;
        1: out_ready_i = $urandom_range(0, 1);
        default: out_ready_i = ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic idle(input int n);
    if (n > 0) begin
      in_valid_i = 1'b0;
      repeat (n) @(negedge clk_i);
    end
  endtask

  task automatic send_item(input logic [KindW-1:0] kind, input int item, input int dim,
                           input int val);
    in_valid_i = 1'b1;
    in_kind_i = kind;
    in_item_index_i = item;
    in_dim_index_i = dim;
    in_value_i = val;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    items_sent++;
    if (kind == KindLoadCent && item < 8) cent_written[item*8+dim] = 1'b1;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      idle(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12));
      burst_left = $urandom_range(1, 30);
    end
  endtask

  task automatic drain();
    idle(1);
    while (pending != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [PdataW-1:0] data);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = data;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic read_cent_rand(input int k, input int d);
    int c;
    int m;
    c = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 1023) : $urandom_range(0, k - 1);
    m = $urandom_range(0, d - 1);
    if (c < 8 && !cent_written[c*8+m]) c = $urandom_range(8, 1023);
    send_item(KindReadCent, c, m, $urandom);
  endtask

  task automatic noise_item();
    case ($urandom_range(0, 3))
      0: send_item(KindSpare5 + $urandom_range(0, 2), $urandom, $urandom, $urandom);
      1: send_item(KindLoadCent, $urandom_range(8, 1023), $urandom, $urandom);
      2: send_item(KindReadLabel, $urandom, $urandom, $urandom);
      default: send_item(KindReadCent, $urandom_range(8, 1023), $urandom, $urandom);
    endcase
  endtask

  task automatic cluster_phase(input bit hold);
    int kw, dw, nw, lw;
    int k, d, n;
    int spread;
    int centers[8][8];
    int v;
    kw = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 0 : 15) : $urandom_range(1, 4);
    if ($urandom_range(0, 9) == 0) kw = 8;
    dw = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 0 : 15) : $urandom_range(1, 3);
    if ($urandom_range(0, 9) == 0) dw = 8;
    nw = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 12);
    case ($urandom_range(0, 11))
      0: lw = 0;
      1: lw = 65535;
      2: lw = 1001;
      default: lw = $urandom_range(0, 8);
    endcase
    k = (kw < 1) ? 1 : (kw > 8) ? 8 : kw;
    d = (dw < 1) ? 1 : (dw > 8) ? 8 : dw;
    n = (nw < 1) ? 1 : nw;
    cfg_write(RegNumClusters, {$urandom, 4'h0} | kw);
    cfg_write(RegNumDims, {$urandom, 4'h0} | dw);
    cfg_write(RegNumPoints, {$urandom, 11'h0} | nw);
    cfg_write(RegMaxUpdates, {$urandom, 16'h0} | lw);
    spread = ($urandom_range(0, 1)) ? 200 : 4000;
    for (int c = 0; c < 8; c++)
      for (int m = 0; m < 8; m++) centers[c][m] = $urandom_range(0, 40000) - 20000;
    for (int c = 0; c < k; c++)
      for (int m = 0; m < d; m++) begin
        if ($urandom_range(0, 9) == 0) noise_item();
        send_item(KindLoadCent, c, m, $urandom);
      end
    for (int i = 0; i < n; i++)
      for (int m = 0; m < d; m++) begin
        if ($urandom_range(0, 9) == 0) noise_item();
        if ($urandom_range(0, 3) == 0) v = $urandom;
        else v = centers[$urandom_range(0, k - 1)][m] + $urandom_range(0, 2*spread) - spread;
        send_item(KindLoadPoint, i, m, v);
      end
    if ($urandom_range(0, 3) == 0) send_item(KindReadLabel, $urandom_range(0, n - 1), 0, 0);
    send_item(KindStart, $urandom, $urandom, $urandom);
    if ($urandom_range(0, 5) == 0) send_item(KindStart, $urandom, $urandom, $urandom);
    if (hold) long_hold = 1'b1;
    repeat ($urandom_range(3, 10)) begin
      if ($urandom_range(0, 1)) send_item(KindReadLabel, $urandom_range(0, n - 1), $urandom, 0);
      else read_cent_rand(k, d);
    end
    if (hold) repeat (20) send_item(KindReadLabel, $urandom, $urandom, $urandom);
    drain();
  endtask

  initial begin
    int ph;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_kind_i = '0;
    in_item_index_i = '0;
    in_dim_index_i = '0;
    in_value_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    long_hold = 1'b0;
    burst_left = 0;
    items_sent = 0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: reset configuration, extreme values, ignored and out-of-range items
    send_item(KindReadLabel, 0, 0, 0);
    send_item(KindReadLabel, 1023, 7, 0);
    send_item(KindLoadCent, 0, 0, -32768);
    send_item(KindLoadCent, 0, 1, -32768);
    send_item(KindLoadCent, 1, 0, 32767);
    send_item(KindLoadCent, 1, 1, 32767);
    send_item(KindLoadPoint, 0, 0, 32767);
    send_item(KindLoadPoint, 0, 1, -32768);
    send_item(KindLoadCent, 1023, 7, 1234);
    send_item(KindSpare5, 5, 5, 5);
    send_item(KindSpare6, 1023, 7, -1);
    send_item(KindSpare7, 0, 0, 0);
    send_item(KindStart, 0, 0, 0);
    send_item(KindReadLabel, 0, 0, 0);
    send_item(KindReadCent, 0, 0, 0);
    send_item(KindReadCent, 1, 1, 0);
    send_item(KindReadCent, 1023, 7, 0);
    send_item(KindReadCent, 8, 0, 0);
    send_item(KindStart, 1023, 7, 32767);
    drain();

    ph = 0;
    while (items_sent < 600) begin
      cluster_phase(ph == 3);
      ph++;
    end

    // larger data set: one coordinate, two clusters
    cfg_write(RegNumClusters, 2);
    cfg_write(RegNumDims, 1);
    cfg_write(RegNumPoints, 200);
    cfg_write(RegMaxUpdates, 3);
    send_item(KindLoadCent, 0, 0, -100);
    send_item(KindLoadCent, 1, 0, 100);
    for (int i = 0; i < 200; i++) send_item(KindLoadPoint, i, 0, $urandom);
    send_item(KindStart, 0, 0, 0);
    send_item(KindReadLabel, 199, 0, 0);
    send_item(KindReadCent, 0, 0, 0);
    send_item(KindReadCent, 1, 0, 0);
    drain();

    if (error_count == 0) begin
      $display("[kmeans_cluster_engine] OK");
    end else begin
      $display("[kmeans_cluster_engine] ERROR");
    end
    $finish;
  end
endmodule
